### design/bev_pkg.sv
// Package for the bird's-eye-view grid binning block: sizes, cell word type,
// state codes and the density table built at elaboration.
// Depends on nothing; used by point_to_bev_grid_binning_top.
package bev_pkg;

  localparam int GRID_WIDTH         = 256;
  localparam int GRID_HEIGHT        = 256;
  localparam int DENSITY_SATURATION = 64;

  localparam int COORD_W = 19;
  localparam int SUM_W   = 24;
  localparam int OFF_W   = 20;
  localparam int CNT_W   = 16;
  localparam int ADDR_W  = 16;
  localparam int OUT_W   = 16;
  localparam int CFG_W   = 19;
  localparam int CFG_IDX_W = 3;

  localparam int COL_W  = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int ROW_W  = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int DIDX_W = $clog2(DENSITY_SATURATION);

  // Shared divider: 40 bit dividend, 20 bit divisor, one quotient bit a cycle.
  localparam int DVD_W   = 40;
  localparam int DVS_W   = 20;
  localparam int DCNT_W  = 6;
  localparam int LOG_FRAC = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LOW     = 3'd0,
    REG_X_HIGH    = 3'd1,
    REG_Y_LOW     = 3'd2,
    REG_Y_HIGH    = 3'd3,
    REG_Z_LOW     = 3'd4,
    REG_Z_HIGH    = 3'd5,
    REG_CELL_SIZE = 3'd6
  } cfg_reg_e;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_DECODE  = 9'b000000100,
    S_DIVCOL  = 9'b000001000,
    S_DIVROW  = 9'b000010000,
    S_MEMRD   = 9'b000100000,
    S_UPDATE  = 9'b001000000,
    S_DIVMEAN = 9'b010000000,
    S_DIVFRAC = 9'b100000000
  } state_e;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [OFF_W-1:0] off;
    logic [CNT_W-1:0] cnt;
  } cell_t;

  typedef logic [DENSITY_SATURATION-1:0][OUT_W-1:0] dens_tab_t;

  // log2(n) with 24 fraction bits, by repeated squaring of a Q1.30 mantissa.
  function automatic logic [63:0] log2_fixed(input logic [31:0] n);
    logic [63:0] m;
    logic [63:0] frac;
    int          k;
    k    = 0;
    frac = '0;
    for (int b = 0; b < 31; b++) begin
      if ((n >> (b + 1)) != 0) k = b + 1;
    end
    m = ({32'd0, n} << 30) >> k;
    for (int i = LOG_FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m       = m >> 1;
        frac[i] = 1'b1;
      end
    end
    return (64'(k) << LOG_FRAC) | frac;
  endfunction

  function automatic dens_tab_t build_dens_tab();
    dens_tab_t   tab;
    logic [63:0] num;
    logic [63:0] den;
    logic [64:0] rem;
    logic [63:0] quo;
    for (int i = 0; i < DENSITY_SATURATION; i++) begin
      if (i + 1 >= DENSITY_SATURATION) begin
        tab[i] = '1;
      end else begin
        num = log2_fixed(32'(i + 1)) << 16;
        den = log2_fixed(32'(DENSITY_SATURATION));
        rem = '0;
        quo = '0;
        // Long division by shift and subtract.
        for (int b = 63; b >= 0; b--) begin
          rem = {rem[63:0], num[b]};
          if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
          end
        end
        tab[i] = (quo > 64'd65535) ? 16'hffff : quo[15:0];
      end
    end
    return tab;
  endfunction

  localparam dens_tab_t DENS_TAB = build_dens_tab();

endpackage

### design/point_to_bev_grid_binning_top.sv
// Top level of the bird's-eye-view grid binning block: handshakes, register
// file, cell memory, shared serial divider and control sequencer.
// Depends on bev_pkg.

// The block works on one word at a time. After reset it first sweeps the
// whole cell memory to zero, one cell a cycle; during that sweep no input
// word is accepted, though register writes are taken. An add word that
// falls outside the box is answered straight from the decode state. For an
// add word inside the box, the column and the row are each found by a shared
// restoring divider that produces one quotient bit a cycle, followed by a
// state to read the cell and one to write it back. A read word reads the
// cell and clears it; the mean intensity and the height fraction then each
// pass through the same divider. The result sits in an output register,
// so the next input word may be taken while the previous result still waits
// for the consumer. Registers may be written only while the block holds no
// unfinished word.
module point_to_bev_grid_binning_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [bev_pkg::CFG_IDX_W-1:0]          cfg_addr_i,
  input  logic [bev_pkg::CFG_W-1:0]              cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   command_i,
  input  logic signed [bev_pkg::COORD_W-1:0]     point_x_i,
  input  logic signed [bev_pkg::COORD_W-1:0]     point_y_i,
  input  logic signed [bev_pkg::COORD_W-1:0]     point_z_i,
  input  logic [7:0]                             point_intensity_i,
  input  logic [bev_pkg::ADDR_W-1:0]             read_cell_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   in_range_o,
  output logic [bev_pkg::ADDR_W-1:0]             cell_index_o,
  output logic [bev_pkg::OUT_W-1:0]              mean_intensity_o,
  output logic [bev_pkg::OUT_W-1:0]              height_fraction_o,
  output logic [bev_pkg::OUT_W-1:0]              density_o,
  output logic [bev_pkg::OUT_W-1:0]              point_count_o
);

  // Configuration registers.
  logic signed [bev_pkg::COORD_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q;
  logic signed [bev_pkg::COORD_W-1:0] z_low_q, z_high_q;
  logic [15:0]                        cell_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q     <= 19'sd0;
      x_high_q    <= 19'sd25600;
      y_low_q     <= -19'sd12800;
      y_high_q    <= 19'sd12800;
      z_low_q     <= -19'sd3000;
      z_high_q    <= 19'sd1000;
      cell_size_q <= 16'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bev_pkg::REG_X_LOW:     x_low_q     <= cfg_wdata_i;
        bev_pkg::REG_X_HIGH:    x_high_q    <= cfg_wdata_i;
        bev_pkg::REG_Y_LOW:     y_low_q     <= cfg_wdata_i;
        bev_pkg::REG_Y_HIGH:    y_high_q    <= cfg_wdata_i;
        bev_pkg::REG_Z_LOW:     z_low_q     <= cfg_wdata_i;
        bev_pkg::REG_Z_HIGH:    z_high_q    <= cfg_wdata_i;
        bev_pkg::REG_CELL_SIZE: cell_size_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and captured input word.
  bev_pkg::state_e state_q, state_d;
  logic                                cmd_q;
  logic signed [bev_pkg::COORD_W-1:0]  px_q, py_q, pz_q;
  logic [7:0]                          inten_q;
  logic [bev_pkg::ADDR_W-1:0]          cell_q, cell_d;
  logic                                inrng_q, inrng_d;
  logic [bev_pkg::COL_W-1:0]           col_q, col_d;
  logic [bev_pkg::SUM_W-1:0]           sum_q, sum_d;
  logic [bev_pkg::OFF_W-1:0]           off_q, off_d;
  logic [bev_pkg::CNT_W-1:0]           cnt_q, cnt_d;
  logic [bev_pkg::OUT_W-1:0]           mean_q, mean_d;
  logic [bev_pkg::OUT_W-1:0]           frac_q, frac_d;
  logic [bev_pkg::ADDR_W-1:0]          clr_q, clr_d;
  logic                                fin_q, fin_d;

  // Divider registers.
  logic [bev_pkg::DVD_W-1:0]  dvd_q, dvd_d;
  logic [bev_pkg::DVS_W-1:0]  dvs_q, dvs_d;
  logic [bev_pkg::DVS_W-1:0]  rem_q, rem_d;
  logic [bev_pkg::DCNT_W-1:0] dcnt_q, dcnt_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic                       o_inrng_q, o_inrng_d;
  logic [bev_pkg::ADDR_W-1:0] o_cell_q, o_cell_d;
  logic [bev_pkg::OUT_W-1:0]  o_mean_q, o_mean_d, o_frac_q, o_frac_d;
  logic [bev_pkg::OUT_W-1:0]  o_dens_q, o_dens_d, o_cnt_q, o_cnt_d;

  // Cell memory with one write and one registered read port.
  bev_pkg::cell_t             cell_mem [2**bev_pkg::ADDR_W];
  bev_pkg::cell_t             rdata_q;
  bev_pkg::cell_t             wdata;
  logic                       mem_we;
  logic [bev_pkg::ADDR_W-1:0] mem_waddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= wdata;
    end
    rdata_q <= cell_mem[cell_q];
  end

  // One restoring step of the divider.
  logic [bev_pkg::DVS_W:0]   shifted;
  logic [bev_pkg::DVS_W+1:0] diff;
  logic [bev_pkg::DVD_W-1:0] quo;
  logic                      div_last;
  logic [bev_pkg::OUT_W-1:0] quo_sat;

  assign shifted  = {rem_q, dvd_q[bev_pkg::DVD_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dvs_q};
  assign quo      = {dvd_q[bev_pkg::DVD_W-2:0], ~diff[bev_pkg::DVS_W+1]};
  assign div_last = (dcnt_q == bev_pkg::DCNT_W'(bev_pkg::DVD_W - 1));
  assign quo_sat  = (quo[bev_pkg::DVD_W-1:bev_pkg::OUT_W] != '0) ? '1
                                                                  : quo[bev_pkg::OUT_W-1:0];

  // Box test, offsets and clamping.
  logic signed [bev_pkg::COORD_W:0] dx, dy, dz, zrange;
  logic                             in_box;
  logic [15:0]                      cs_eff;
  logic [bev_pkg::COL_W-1:0]        col_clamp;
  logic [bev_pkg::ROW_W-1:0]        row_clamp;
  logic [31:0]                      idx_full;
  logic [bev_pkg::SUM_W:0]          sum_add;
  logic [bev_pkg::OUT_W-1:0]        dens;

  assign dx     = {px_q[18], px_q} - {x_low_q[18], x_low_q};
  assign dy     = {y_high_q[18], y_high_q} - {py_q[18], py_q};
  assign dz     = {pz_q[18], pz_q} - {z_low_q[18], z_low_q};
  assign zrange = {z_high_q[18], z_high_q} - {z_low_q[18], z_low_q};
  assign in_box = (px_q >= x_low_q) && (px_q <= x_high_q) &&
                  (py_q >= y_low_q) && (py_q <= y_high_q) &&
                  (pz_q >= z_low_q) && (pz_q <= z_high_q);
  assign cs_eff = (cell_size_q == '0) ? 16'd1 : cell_size_q;

  assign col_clamp = (quo > bev_pkg::DVD_W'(bev_pkg::GRID_WIDTH - 1))
                     ? bev_pkg::COL_W'(bev_pkg::GRID_WIDTH - 1)
                     : quo[bev_pkg::COL_W-1:0];
  assign row_clamp = (quo > bev_pkg::DVD_W'(bev_pkg::GRID_HEIGHT - 1))
                     ? bev_pkg::ROW_W'(bev_pkg::GRID_HEIGHT - 1)
                     : quo[bev_pkg::ROW_W-1:0];
  assign idx_full  = 32'(row_clamp) * 32'(bev_pkg::GRID_WIDTH) + 32'(col_q);

  assign sum_add = {1'b0, rdata_q.sum} + (bev_pkg::SUM_W + 1)'(inten_q);

  // Density: the table covers counts below the saturation point.
  assign dens = (32'(cnt_q) >= 32'(bev_pkg::DENSITY_SATURATION - 1)) ? '1
                : bev_pkg::DENS_TAB[cnt_q[bev_pkg::DIDX_W-1:0]];

  assign in_ready_o = (state_q == bev_pkg::S_IDLE) && !fin_q;

  always_comb begin
    state_d     = state_q;
    cell_d      = cell_q;
    inrng_d     = inrng_q;
    col_d       = col_q;
    sum_d       = sum_q;
    off_d       = off_q;
    cnt_d       = cnt_q;
    mean_d      = mean_q;
    frac_d      = frac_q;
    clr_d       = clr_q;
    fin_d       = fin_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    mem_we      = 1'b0;
    mem_waddr   = cell_q;
    wdata       = '0;

    unique case (state_q)
      bev_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = bev_pkg::S_IDLE;
        end
      end
      bev_pkg::S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          state_d = bev_pkg::S_DECODE;
        end
      end
      bev_pkg::S_DECODE: begin
        dcnt_d = '0;
        rem_d  = '0;
        if (cmd_q == bev_pkg::CMD_READ) begin
          state_d = bev_pkg::S_MEMRD;
        end else if (!in_box) begin
          inrng_d = 1'b0;
          cell_d  = '0;
          sum_d   = '0;
          off_d   = '0;
          cnt_d   = '0;
          fin_d   = 1'b1;
          state_d = bev_pkg::S_IDLE;
        end else begin
          inrng_d = 1'b1;
          dvd_d   = bev_pkg::DVD_W'(dx[bev_pkg::COORD_W:0]);
          dvs_d   = bev_pkg::DVS_W'(cs_eff);
          state_d = bev_pkg::S_DIVCOL;
        end
      end
      bev_pkg::S_DIVCOL: begin
        dvd_d  = quo;
        rem_d  = diff[bev_pkg::DVS_W+1] ? shifted[bev_pkg::DVS_W-1:0]
                                         : diff[bev_pkg::DVS_W-1:0];
        dcnt_d = dcnt_q + 1'b1;
        if (div_last) begin
          col_d   = col_clamp;
          dvd_d   = bev_pkg::DVD_W'(dy[bev_pkg::COORD_W:0]);
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = bev_pkg::S_DIVROW;
        end
      end
      bev_pkg::S_DIVROW: begin
        dvd_d  = quo;
        rem_d  = diff[bev_pkg::DVS_W+1] ? shifted[bev_pkg::DVS_W-1:0]
                                         : diff[bev_pkg::DVS_W-1:0];
        dcnt_d = dcnt_q + 1'b1;
        if (div_last) begin
          cell_d  = idx_full[bev_pkg::ADDR_W-1:0];
          state_d = bev_pkg::S_MEMRD;
        end
      end
      bev_pkg::S_MEMRD: begin
        state_d = bev_pkg::S_UPDATE;
      end
      bev_pkg::S_UPDATE: begin
        mem_we = 1'b1;
        if (cmd_q == bev_pkg::CMD_ADD) begin
          wdata.sum = sum_add[bev_pkg::SUM_W] ? '1 : sum_add[bev_pkg::SUM_W-1:0];
          wdata.off = (dz[bev_pkg::OFF_W-1:0] > rdata_q.off) ? dz[bev_pkg::OFF_W-1:0]
                                                             : rdata_q.off;
          wdata.cnt = (rdata_q.cnt == '1) ? rdata_q.cnt : rdata_q.cnt + 1'b1;
          sum_d     = '0;
          off_d     = '0;
          cnt_d     = '0;
          fin_d     = 1'b1;
          state_d   = bev_pkg::S_IDLE;
        end else begin
          // Read clears the cell while its contents move to the divider.
          inrng_d = 1'b0;
          sum_d   = rdata_q.sum;
          off_d   = rdata_q.off;
          cnt_d   = rdata_q.cnt;
          dvd_d   = bev_pkg::DVD_W'({rdata_q.sum, 8'd0});
          dvs_d   = bev_pkg::DVS_W'(rdata_q.cnt);
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = bev_pkg::S_DIVMEAN;
        end
      end
      bev_pkg::S_DIVMEAN: begin
        dvd_d  = quo;
        rem_d  = diff[bev_pkg::DVS_W+1] ? shifted[bev_pkg::DVS_W-1:0]
                                         : diff[bev_pkg::DVS_W-1:0];
        dcnt_d = dcnt_q + 1'b1;
        if (div_last) begin
          mean_d  = (cnt_q == '0) ? '0 : quo_sat;
          dvd_d   = bev_pkg::DVD_W'({off_q, 16'd0});
          dvs_d   = zrange[bev_pkg::DVS_W-1:0];
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = bev_pkg::S_DIVFRAC;
        end
      end
      bev_pkg::S_DIVFRAC: begin
        dvd_d  = quo;
        rem_d  = diff[bev_pkg::DVS_W+1] ? shifted[bev_pkg::DVS_W-1:0]
                                         : diff[bev_pkg::DVS_W-1:0];
        dcnt_d = dcnt_q + 1'b1;
        if (div_last) begin
          // The z range is taken with the registers as they stand now.
          frac_d  = (zrange > 0) ? quo_sat : '0;
          fin_d   = 1'b1;
          state_d = bev_pkg::S_IDLE;
        end
      end
      default: state_d = bev_pkg::S_IDLE;
    endcase

    // A finished word moves into the output register once it is free.
    out_valid_d = out_valid_q;
    o_inrng_d   = o_inrng_q;
    o_cell_d    = o_cell_q;
    o_mean_d    = o_mean_q;
    o_frac_d    = o_frac_q;
    o_dens_d    = o_dens_q;
    o_cnt_d     = o_cnt_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fin_q && (!out_valid_q || out_ready_i)) begin
      fin_d       = 1'b0;
      out_valid_d = 1'b1;
      o_inrng_d   = inrng_q;
      o_cell_d    = cell_q;
      if (cmd_q == bev_pkg::CMD_READ) begin
        o_mean_d = mean_q;
        o_frac_d = frac_q;
        o_dens_d = dens;
        o_cnt_d  = cnt_q;
      end else begin
        o_mean_d = '0;
        o_frac_d = '0;
        o_dens_d = '0;
        o_cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bev_pkg::S_CLEAR;
      clr_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= command_i;
      px_q    <= point_x_i;
      py_q    <= point_y_i;
      pz_q    <= point_z_i;
      inten_q <= point_intensity_i;
      cell_q  <= read_cell_i;
    end else begin
      cell_q  <= cell_d;
    end
    inrng_q   <= inrng_d;
    col_q     <= col_d;
    sum_q     <= sum_d;
    off_q     <= off_d;
    cnt_q     <= cnt_d;
    mean_q    <= mean_d;
    frac_q    <= frac_d;
    dvd_q     <= dvd_d;
    dvs_q     <= dvs_d;
    rem_q     <= rem_d;
    o_inrng_q <= o_inrng_d;
    o_cell_q  <= o_cell_d;
    o_mean_q  <= o_mean_d;
    o_frac_q  <= o_frac_d;
    o_dens_q  <= o_dens_d;
    o_cnt_q   <= o_cnt_d;
  end

  assign out_valid_o       = out_valid_q;
  assign in_range_o        = o_inrng_q;
  assign cell_index_o      = o_cell_q;
  assign mean_intensity_o  = o_mean_q;
  assign height_fraction_o = o_frac_q;
  assign density_o         = o_dens_q;
  assign point_count_o     = o_cnt_q;

endmodule

### tb/point_to_bev_grid_binning_top_tb.sv
// Testbench for the bird's-eye-view grid binning block: directed table plus
// random words, checked against typed results or a cycle-free predictor of the cell store.
// Depends on bev_pkg and point_to_bev_grid_binning_top.
module point_to_bev_grid_binning_top_tb;

  // One word into the block, as its fields.
  typedef struct {
    logic                               cmd;
    logic signed [bev_pkg::COORD_W-1:0] x;
    logic signed [bev_pkg::COORD_W-1:0] y;
    logic signed [bev_pkg::COORD_W-1:0] z;
    logic [7:0]                         inten;
    logic [bev_pkg::ADDR_W-1:0]         addr;
  } point_word_t;

  // One result word out of the block.
  typedef struct packed {
    logic                       in_range;
    logic [bev_pkg::ADDR_W-1:0] cell_index;
    logic [bev_pkg::OUT_W-1:0]  mean;
    logic [bev_pkg::OUT_W-1:0]  hfrac;
    logic [bev_pkg::OUT_W-1:0]  dens;
    logic [bev_pkg::OUT_W-1:0]  cnt;
  } bin_result_t;

  // A directed row: the word, and where it is obvious, the result typed in.
  typedef struct {
    point_word_t w;
    bit          fixed;
    bin_result_t res;
  } dir_row_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [bev_pkg::CFG_IDX_W-1:0]      cfg_addr_i;
  logic [bev_pkg::CFG_W-1:0]          cfg_wdata_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic                               command_i;
  logic signed [bev_pkg::COORD_W-1:0] point_x_i;
  logic signed [bev_pkg::COORD_W-1:0] point_y_i;
  logic signed [bev_pkg::COORD_W-1:0] point_z_i;
  logic [7:0]                         point_intensity_i;
  logic [bev_pkg::ADDR_W-1:0]         read_cell_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic                               in_range_o;
  logic [bev_pkg::ADDR_W-1:0]         cell_index_o;
  logic [bev_pkg::OUT_W-1:0]          mean_intensity_o;
  logic [bev_pkg::OUT_W-1:0]          height_fraction_o;
  logic [bev_pkg::OUT_W-1:0]          density_o;
  logic [bev_pkg::OUT_W-1:0]          point_count_o;

  point_to_bev_grid_binning_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .point_x_i,
    .point_y_i,
    .point_z_i,
    .point_intensity_i,
    .read_cell_i,
    .out_valid_o,
    .out_ready_i,
    .in_range_o,
    .cell_index_o,
    .mean_intensity_o,
    .height_fraction_o,
    .density_o,
    .point_count_o
  );

  // The predictor's own copy of the registers and of the cell store.
  int          box_x_lo, box_x_hi, box_y_lo, box_y_hi, box_z_lo, box_z_hi;
  int unsigned cell_edge;
  logic [bev_pkg::SUM_W-1:0] acc_sum [65536];
  logic [bev_pkg::OFF_W-1:0] acc_top [65536];
  logic [bev_pkg::CNT_W-1:0] acc_cnt [65536];

  bin_result_t                pending_results[$];
  logic [bev_pkg::ADDR_W-1:0] touched_cells[$];
  int                         mismatches;
  int                         burst_left;

  // log2(n) with 24 fraction bits; the mantissa is squared and truncated
  // once per fraction bit.
  function automatic longint unsigned log2_q24(int unsigned n);
    int              k;
    longint unsigned m;
    longint unsigned fr;
    k  = 0;
    fr = 0;
    if (n == 0) return 0;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    m = (longint'(n) << 30) >> k;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        fr |= 64'd1 << i;
      end
    end
    return (longint'(k) << 24) | fr;
  endfunction

  function automatic logic [bev_pkg::OUT_W-1:0] density_for(int unsigned count);
    longint unsigned q;
    if (count + 1 >= bev_pkg::DENSITY_SATURATION) return 16'hffff;
    q = (log2_q24(count + 1) << 16) / log2_q24(bev_pkg::DENSITY_SATURATION);
    return (q > 65535) ? 16'hffff : q[15:0];
  endfunction

  // Applies one word to the predicted store and returns the result it gives.
  function automatic bin_result_t bin_word(point_word_t w);
    bin_result_t               r;
    int                        px, py, pz, col, row, cs, rng;
    int unsigned               s;
    logic [15:0]               idx;
    logic [bev_pkg::OFF_W-1:0] off;
    longint unsigned           q;
    r  = '0;
    px = w.x;
    py = w.y;
    pz = w.z;
    if (w.cmd == bev_pkg::CMD_ADD) begin
      cs = (cell_edge == 0) ? 1 : cell_edge;
      if (px < box_x_lo || px > box_x_hi || py < box_y_lo || py > box_y_hi ||
          pz < box_z_lo || pz > box_z_hi) return r;
      col = (px - box_x_lo) / cs;
      row = (box_y_hi - py) / cs;
      if (col > bev_pkg::GRID_WIDTH - 1) col = bev_pkg::GRID_WIDTH - 1;
      if (row > bev_pkg::GRID_HEIGHT - 1) row = bev_pkg::GRID_HEIGHT - 1;
      idx = 16'(row * bev_pkg::GRID_WIDTH + col);
      off = bev_pkg::OFF_W'(pz - box_z_lo);
      s   = acc_sum[idx] + w.inten;
      acc_sum[idx] = (s > 24'hffffff) ? 24'hffffff : s[23:0];
      if (off > acc_top[idx]) acc_top[idx] = off;
      if (acc_cnt[idx] != 16'hffff) acc_cnt[idx]++;
      r.in_range   = 1'b1;
      r.cell_index = idx;
      touched_cells = {touched_cells, idx};
      if (touched_cells.size() > 64) void'(touched_cells.pop_front());
    end else begin
      idx          = w.addr;
      r.cell_index = idx;
      if (acc_cnt[idx] != 0) begin
        q      = (longint'(acc_sum[idx]) << 8) / acc_cnt[idx];
        r.mean = (q > 65535) ? 16'hffff : q[15:0];
      end
      rng = box_z_hi - box_z_lo;
      if (rng > 0) begin
        q       = (longint'(acc_top[idx]) << 16) / rng;
        r.hfrac = (q > 65535) ? 16'hffff : q[15:0];
      end
      r.dens = density_for(acc_cnt[idx]);
      r.cnt  = acc_cnt[idx];
      acc_sum[idx] = '0;
      acc_top[idx] = '0;
      acc_cnt[idx] = '0;
    end
    return r;
  endfunction

  // Directed words under the reset box [0..25600] x [-12800..12800] x
  // [-3000..1000] with 100 mm cells.
  dir_row_t dir_tab [21] = '{
    // Reads of cells never written come back empty, at both ends of the store.
    '{'{bev_pkg::CMD_READ, 0, 0, 0, 0, 16'h0000}, 1, '{0, 16'h0000, 0, 0, 0, 0}},
    '{'{bev_pkg::CMD_READ, -262144, 262143, -1, 255, 16'hffff}, 1,
      '{0, 16'hffff, 0, 0, 0, 0}},
    // Points just outside five faces of the box (all but the upper y face) are rejected.
    '{'{bev_pkg::CMD_ADD, -1, 0, 0, 7, 16'hffff}, 1, '{0, 0, 0, 0, 0, 0}},
    // Corner points: top left lands in cell 0, far corner clamps to the last.
    '{'{bev_pkg::CMD_ADD, 0, 12800, -3000, 0, 16'h0000}, 1,
      '{1, 16'h0000, 0, 0, 0, 0}},
    '{'{bev_pkg::CMD_ADD, 25600, -12800, 1000, 255, 16'h0000}, 1,
      '{1, 16'hffff, 0, 0, 0, 0}},
    '{'{bev_pkg::CMD_ADD, 25601, 0, 0, 1, 16'h0000}, 1, '{0, 0, 0, 0, 0, 0}},
    '{'{bev_pkg::CMD_ADD, 0, -12801, 0, 1, 16'h0000}, 1, '{0, 0, 0, 0, 0, 0}},
    '{'{bev_pkg::CMD_ADD, 0, 0, 1001, 1, 16'h0000}, 1, '{0, 0, 0, 0, 0, 0}},
    '{'{bev_pkg::CMD_ADD, 0, 0, -3001, 1, 16'h0000}, 1, '{0, 0, 0, 0, 0, 0}},
    '{'{bev_pkg::CMD_ADD, 262143, -262144, 262143, 255, 16'hffff}, 1,
      '{0, 0, 0, 0, 0, 0}},
    // Three points into cell 1, then read it twice: the second read is empty.
    '{'{bev_pkg::CMD_ADD, 150, 12750, 0, 200, 16'h0000}, 1,
      '{1, 16'h0001, 0, 0, 0, 0}},
    '{'{bev_pkg::CMD_ADD, 199, 12701, -2000, 100, 16'h0000}, 1,
      '{1, 16'h0001, 0, 0, 0, 0}},
    '{'{bev_pkg::CMD_ADD, 100, 12800, 500, 255, 16'h0000}, 1,
      '{1, 16'h0001, 0, 0, 0, 0}},
    '{'{bev_pkg::CMD_READ, 0, 0, 0, 0, 16'h0001}, 0, '0},
    '{'{bev_pkg::CMD_READ, 0, 0, 0, 0, 16'h0001}, 1, '{0, 16'h0001, 0, 0, 0, 0}},
    '{'{bev_pkg::CMD_READ, 0, 0, 0, 0, 16'h0000}, 0, '0},
    '{'{bev_pkg::CMD_READ, 0, 0, 0, 0, 16'hffff}, 0, '0},
    '{'{bev_pkg::CMD_ADD, 12345, -5, -2999, 170, 16'h5555}, 0, '0},
    '{'{bev_pkg::CMD_READ, 0, 0, 0, 0, 16'd32891}, 0, '0},
    '{'{bev_pkg::CMD_READ, -1, -1, -1, 255, 16'haaaa}, 1,
      '{0, 16'haaaa, 0, 0, 0, 0}},
    '{'{bev_pkg::CMD_READ, 0, 0, 0, 0, 16'h5555}, 1, '{0, 16'h5555, 0, 0, 0, 0}}
  };

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Generous ceiling: the clearing sweep plus every word at its slowest.
  initial begin
    #30000000;
    $display("status: fail");
    $finish;
  end

  // Register write; the predictor takes the new value at the same moment.
  task automatic cfg_write(bev_pkg::cfg_reg_e idx, int val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= bev_pkg::CFG_W'(val);
    case (idx)
      bev_pkg::REG_X_LOW:  box_x_lo = val;
      bev_pkg::REG_X_HIGH: box_x_hi = val;
      bev_pkg::REG_Y_LOW:  box_y_lo = val;
      bev_pkg::REG_Y_HIGH: box_y_hi = val;
      bev_pkg::REG_Z_LOW:  box_z_lo = val;
      bev_pkg::REG_Z_HIGH: box_z_hi = val;
      default:             cell_edge = val & 16'hffff;
    endcase
    @(posedge clk_i);
  endtask

  // Presents one word, holds it until it is taken and records what it should
  // produce. Called just after a rising edge; returns at the accepting edge.
  task automatic send_word(point_word_t w, bit fixed, bin_result_t typed);
    bin_result_t r;
    if (burst_left == 0) begin
      // A gap before each burst keeps valid from being lowered and
      // raised in the same step.
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
    end
    in_valid_i        <= 1'b1;
    command_i         <= w.cmd;
    point_x_i         <= w.x;
    point_y_i         <= w.y;
    point_z_i         <= w.z;
    point_intensity_i <= w.inten;
    read_cell_i       <= w.addr;
    do @(posedge clk_i); while (!in_ready_o);
    r = bin_word(w);
    pending_results = {pending_results, (fixed ? typed : r)};
    burst_left--;
  endtask

  // Lets the block run dry, then waits out any word still in flight.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic int pick_coord(int lo, int hi);
    int v;
    if (hi < lo) return $signed(bev_pkg::COORD_W'($urandom_range(0, 524287)));
    v = lo - 2 + int'($urandom_range(0, hi - lo + 4));
    if (v < -262144) v = -262144;
    if (v > 262143) v = 262143;
    return v;
  endfunction

  // Mostly well-formed points inside the box, reads aimed at cells that
  // hold points, and some noise across the whole coordinate range.
  task automatic run_random(int n);
    point_word_t w;
    int          r;
    for (int i = 0; i < n; i++) begin
      r       = $urandom_range(0, 99);
      w.x     = bev_pkg::COORD_W'($urandom);
      w.y     = bev_pkg::COORD_W'($urandom);
      w.z     = bev_pkg::COORD_W'($urandom);
      w.inten = 8'($urandom);
      w.addr  = 16'($urandom);
      w.cmd   = (r < 30) ? bev_pkg::CMD_READ : bev_pkg::CMD_ADD;
      if (r < 30 && touched_cells.size() != 0 && $urandom_range(0, 3) != 0)
        w.addr = touched_cells[$urandom_range(0, touched_cells.size() - 1)];
      if (r >= 30 && r < 90) begin
        w.x = pick_coord(box_x_lo, box_x_hi);
        w.y = pick_coord(box_y_lo, box_y_hi);
        w.z = pick_coord(box_z_lo, box_z_hi);
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_addr_i        = bev_pkg::REG_X_LOW;
    cfg_wdata_i       = '0;
    in_valid_i        = 1'b0;
    command_i         = bev_pkg::CMD_ADD;
    point_x_i         = '0;
    point_y_i         = '0;
    point_z_i         = '0;
    point_intensity_i = '0;
    read_cell_i       = '0;
    mismatches        = 0;
    burst_left        = 0;
    box_x_lo  = 0;
    box_x_hi  = 25600;
    box_y_lo  = -12800;
    box_y_hi  = 12800;
    box_z_lo  = -3000;
    box_z_hi  = 1000;
    cell_edge = 100;
    for (int i = 0; i < 65536; i++) begin
      acc_sum[i] = '0;
      acc_top[i] = '0;
      acc_cnt[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings, then random words.
    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].fixed, dir_tab[i].res);
    run_random(130);
    drain();

    // Widest box with the largest cells: everything falls into a handful of
    // cells and the z range is at its maximum.
    cfg_write(bev_pkg::REG_X_LOW, -262144);
    cfg_write(bev_pkg::REG_X_HIGH, 262143);
    cfg_write(bev_pkg::REG_Y_LOW, -262144);
    cfg_write(bev_pkg::REG_Y_HIGH, 262143);
    cfg_write(bev_pkg::REG_Z_LOW, -262144);
    cfg_write(bev_pkg::REG_Z_HIGH, 262143);
    cfg_write(bev_pkg::REG_CELL_SIZE, 65535);
    cfg_we_i <= 1'b0;
    run_random(80);
    drain();

    // Zero cell size behaves as one, and a flat z range gives no height.
    cfg_write(bev_pkg::REG_X_LOW, 0);
    cfg_write(bev_pkg::REG_X_HIGH, 300);
    cfg_write(bev_pkg::REG_Y_LOW, -100);
    cfg_write(bev_pkg::REG_Y_HIGH, 100);
    cfg_write(bev_pkg::REG_Z_LOW, 0);
    cfg_write(bev_pkg::REG_Z_HIGH, 0);
    cfg_write(bev_pkg::REG_CELL_SIZE, 0);
    cfg_we_i <= 1'b0;
    run_random(80);
    drain();

    // Inverted x bounds and inverted z range: no point is accepted, reads
    // still return what earlier phases left behind.
    cfg_write(bev_pkg::REG_X_LOW, 100);
    cfg_write(bev_pkg::REG_X_HIGH, -100);
    cfg_write(bev_pkg::REG_Z_LOW, 50);
    cfg_write(bev_pkg::REG_Z_HIGH, -50);
    cfg_write(bev_pkg::REG_CELL_SIZE, 1);
    cfg_we_i <= 1'b0;
    run_random(40);
    drain();

    // A small dense grid, with one full pause halfway through.
    cfg_write(bev_pkg::REG_X_LOW, -2048);
    cfg_write(bev_pkg::REG_X_HIGH, 2047);
    cfg_write(bev_pkg::REG_Y_LOW, -2048);
    cfg_write(bev_pkg::REG_Y_HIGH, 2047);
    cfg_write(bev_pkg::REG_Z_LOW, -500);
    cfg_write(bev_pkg::REG_Z_HIGH, 500);
    cfg_write(bev_pkg::REG_CELL_SIZE, 16);
    cfg_we_i <= 1'b0;
    run_random(120);
    drain();
    run_random(130);
    drain();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: a free-running cycle counter sets when the stall pattern is drawn
  // anew from always ready, ready half the time and ready one cycle in eight. Each result word
  // is checked against the oldest expectation as it is taken.
  int          stall_cycle;
  int          stall_mode;
  bin_result_t got;
  bin_result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cycle <= 0;
      stall_mode  <= 0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 256 == 255) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
      if (out_valid_o && out_ready_i) begin
        got = '{in_range_o, cell_index_o, mean_intensity_o, height_fraction_o,
                density_o, point_count_o};
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, actual %p", $time, got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
          end
        end
      end
    end
  end

endmodule

### files.f
design/bev_pkg.sv
design/point_to_bev_grid_binning_top.sv
tb/point_to_bev_grid_binning_top_tb.sv
